// ----- design/dtsp_pkg.sv -----
// Shared types and constants of the dead-time state predictor.
package dtsp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int STEP_W     = 16;
   localparam int DAMP_W     = 16;
   localparam int FREQ_W     = 22;
   localparam int COEF_W     = 28;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0] STEP_TIME_RESET = 16'd1092;
   localparam logic [DAMP_W-1:0] DAMPING_RESET   = 16'd4096;
   localparam logic [FREQ_W-1:0] NAT_FREQ_RESET  = 22'd655360;

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_STEP_TIME = 2'd0;
   localparam csr_idx_type CSR_DAMPING   = 2'd1;
   localparam csr_idx_type CSR_NAT_FREQ  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // One Euler step per axis is seven multiplier slots.
   typedef enum logic [2:0] {
      OP_W2U,
      OP_W2V,
      OP_ZA,
      OP_DTV,
      OP_DTA,
      OP_DTD,
      OP_FIN
   } op_type;

   typedef struct packed {
      logic   in_ready;
      logic   load;
      logic   run;
      op_type op;
      logic   shift;
      logic   out_load;
      logic   out_valid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic out_ready;
   } ctrl_status_type;

endpackage

// ----- design/dtsp_req_if.sv -----
// Input channel: measured state and newest drive command.
interface dtsp_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] pos_x;
   logic signed [DATA_WIDTH-1:0] pos_y;
   logic signed [DATA_WIDTH-1:0] heading;
   logic signed [DATA_WIDTH-1:0] vel_x;
   logic signed [DATA_WIDTH-1:0] vel_y;
   logic signed [DATA_WIDTH-1:0] turn_rate;
   logic signed [DATA_WIDTH-1:0] acc_x;
   logic signed [DATA_WIDTH-1:0] acc_y;
   logic signed [DATA_WIDTH-1:0] drive_x;
   logic signed [DATA_WIDTH-1:0] drive_y;
   logic signed [DATA_WIDTH-1:0] drive_turn;

   modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
                   acc_x, acc_y, drive_x, drive_y, drive_turn, input ready);
   modport sink (input valid, pos_x, pos_y, heading, vel_x, vel_y, turn_rate,
                 acc_x, acc_y, drive_x, drive_y, drive_turn, output ready);
endinterface

// ----- design/dtsp_rsp_if.sv -----
// Result channel: predicted state.
interface dtsp_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] pred_pos_x;
   logic signed [DATA_WIDTH-1:0] pred_pos_y;
   logic signed [DATA_WIDTH-1:0] pred_heading;
   logic signed [DATA_WIDTH-1:0] pred_vel_x;
   logic signed [DATA_WIDTH-1:0] pred_vel_y;
   logic signed [DATA_WIDTH-1:0] pred_turn_rate;
   logic signed [DATA_WIDTH-1:0] pred_acc_x;
   logic signed [DATA_WIDTH-1:0] pred_acc_y;
   logic signed [DATA_WIDTH-1:0] pred_acc_turn;

   modport source (output valid, pred_pos_x, pred_pos_y, pred_heading, pred_vel_x,
                   pred_vel_y, pred_turn_rate, pred_acc_x, pred_acc_y, pred_acc_turn,
                   input ready);
   modport sink (input valid, pred_pos_x, pred_pos_y, pred_heading, pred_vel_x,
                 pred_vel_y, pred_turn_rate, pred_acc_x, pred_acc_y, pred_acc_turn,
                 output ready);
endinterface

// ----- design/dead_time_state_predictor.sv -----
// An accepted input runs one Euler step per stored command, then its result enters the result
// register; input is not taken again until then. Each Euler step takes seven slots
// of the one multiplier per axis lane, and steps run oldest command first.
// The result register lets the next item start while a result waits to be taken.
// Reset (synchronous): registers return to defaults, history clears, channels go idle.
module dead_time_state_predictor #(
   parameter int HISTORY_DEPTH = 7,
   parameter int DATA_WIDTH    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   dtsp_req_if.sink                        req_chan,
   dtsp_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dtsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dtsp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dtsp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import dtsp_pkg::*;

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   ctrl_cmd_type     cmd;
   ctrl_status_type  status;
   logic [IDX_W-1:0] idx;

   assign csr_pready = 1'b1;

   dtsp_ctrl #(.HISTORY_DEPTH(HISTORY_DEPTH), .IDX_W(IDX_W)) u_ctrl (
      .clock(clock), .reset(reset), .status(status), .cmd(cmd), .idx(idx)
   );

   dtsp_datapath #(
      .HISTORY_DEPTH(HISTORY_DEPTH), .DATA_WIDTH(DATA_WIDTH), .IDX_W(IDX_W)
   ) u_datapath (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .cmd(cmd), .idx(idx), .status(status)
   );

endmodule

// ----- design/dtsp_lane.sv -----
// One axis of the Euler integrator around a shared rounding multiplier.
module dtsp_lane #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic                                run,
   input  dtsp_pkg::op_type                    op,
   input  logic [dtsp_pkg::COEF_W-1:0]         w2,
   input  logic [dtsp_pkg::COEF_W-1:0]         zw2,
   input  logic [dtsp_pkg::COEF_W-1:0]         dt,
   input  logic signed [DATA_WIDTH-1:0]        init_pos,
   input  logic signed [DATA_WIDTH-1:0]        init_vel,
   input  logic signed [DATA_WIDTH-1:0]        init_acc,
   input  logic signed [DATA_WIDTH-1:0]        u,
   output logic signed [DATA_WIDTH-1:0]        pos,
   output logic signed [DATA_WIDTH-1:0]        vel,
   output logic signed [DATA_WIDTH-1:0]        acc
);
   import dtsp_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int PW  = COEF_W + DW;
   localparam int MW  = PW - FRAC_BITS;

   logic signed [DW-1:0]   pos_ff, vel_ff, acc_ff, prod_ff, prod_in;
   logic signed [DW+1:0]   d_ff;
   logic signed [DW-1:0]   d_sat;
   logic [COEF_W-1:0]      coef_sel;
   logic signed [DW-1:0]   val_sel;
   logic                   val_neg;
   logic [DW-1:0]          val_mag;
   logic [PW-1:0]          prod_raw, prod_rnd;
   logic [MW-1:0]          mag, limit, mag_c;
   logic signed [DW+1:0]   prod_ext;

   function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
                                                    logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1])
         sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      else
         sat_add = s[DW-1:0];
   endfunction

   always_comb begin
      if (d_ff[DW+1:DW-1] == 3'b000 || d_ff[DW+1:DW-1] == 3'b111)
         d_sat = d_ff[DW-1:0];
      else
         d_sat = d_ff[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
   end

   // Operand selection for this slot.
   always_comb begin
      case (op)
         OP_W2U:  begin coef_sel = w2;  val_sel = u;      end
         OP_W2V:  begin coef_sel = w2;  val_sel = vel_ff; end
         OP_ZA:   begin coef_sel = zw2; val_sel = acc_ff; end
         OP_DTV:  begin coef_sel = dt;  val_sel = vel_ff; end
         OP_DTA:  begin coef_sel = dt;  val_sel = acc_ff; end
         OP_DTD:  begin coef_sel = dt;  val_sel = d_sat;  end
         default: begin coef_sel = '0;  val_sel = '0;     end
      endcase
   end

   // Sign-magnitude product, round half away from zero, saturate.
   always_comb begin
      val_neg  = val_sel[DW-1];
      val_mag  = val_neg ? DW'(-val_sel) : DW'(val_sel);
      prod_raw = PW'(coef_sel) * PW'(val_mag);
      prod_rnd = prod_raw + PW'(1 << (FRAC_BITS - 1));
      mag      = prod_rnd[PW-1:FRAC_BITS];
      limit    = val_neg ? (MW'(1) << (DW - 1)) : ((MW'(1) << (DW - 1)) - MW'(1));
      mag_c    = (mag > limit) ? limit : mag;
      prod_in  = val_neg ? -DW'(mag_c) : DW'(mag_c);
      prod_ext = {{2{prod_ff[DW-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= init_pos;
         vel_ff <= init_vel;
         acc_ff <= init_acc;
      end else if (run) begin
         prod_ff <= prod_in;
         // prod_ff holds the product issued in the previous slot
         case (op)
            OP_W2V:  d_ff   <= prod_ext;
            OP_ZA:   d_ff   <= d_ff - prod_ext;
            OP_DTV:  d_ff   <= d_ff - prod_ext;
            OP_DTA:  pos_ff <= sat_add(pos_ff, prod_ff);
            OP_DTD:  vel_ff <= sat_add(vel_ff, prod_ff);
            OP_FIN:  acc_ff <= sat_add(acc_ff, prod_ff);
            default: ;
         endcase
      end
   end

   assign pos = pos_ff;
   assign vel = vel_ff;
   assign acc = acc_ff;

endmodule

// ----- design/dtsp_datapath.sv -----
// Datapath: registers, coefficients, command history, axis lanes, result register.
module dtsp_datapath #(
   parameter int HISTORY_DEPTH = 7,
   parameter int DATA_WIDTH    = 32,
   parameter int IDX_W         = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   dtsp_req_if.sink                           req_chan,
   dtsp_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dtsp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dtsp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dtsp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  dtsp_pkg::ctrl_cmd_type             cmd,
   input  logic [IDX_W-1:0]                   idx,
   output dtsp_pkg::ctrl_status_type          status
);
   import dtsp_pkg::*;

   localparam int DW   = DATA_WIDTH;
   localparam int SQ_W = 2 * FREQ_W;
   localparam int ZW_W = DAMP_W + FREQ_W + 1;

   logic [STEP_W-1:0]    step_time_ff;
   logic [DAMP_W-1:0]    damping_ff;
   logic [FREQ_W-1:0]    nat_freq_ff;
   logic [COEF_W-1:0]    w2_ff, w2_in, zw2_ff, zw2_in, dt_coef;
   logic [SQ_W-1:0]      w_sq;
   logic [ZW_W-1:0]      zw_prod;
   logic                 csr_write;
   csr_idx_type          csr_idx;

   logic signed [DW-1:0] hist_x_ff [HISTORY_DEPTH];
   logic signed [DW-1:0] hist_y_ff [HISTORY_DEPTH];
   logic signed [DW-1:0] hist_t_ff [HISTORY_DEPTH];

   logic signed [DW-1:0] pos [3];
   logic signed [DW-1:0] vel [3];
   logic signed [DW-1:0] acc [3];
   logic signed [DW-1:0] out_ff [9];

   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx   = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         damping_ff   <= DAMPING_RESET;
         nat_freq_ff  <= NAT_FREQ_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_STEP_TIME: step_time_ff <= csr_pwdata[STEP_W-1:0];
            CSR_DAMPING:   damping_ff   <= csr_pwdata[DAMP_W-1:0];
            CSR_NAT_FREQ:  nat_freq_ff  <= csr_pwdata[FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_STEP_TIME: csr_prdata = CSR_DATA_W'(step_time_ff);
         CSR_DAMPING:   csr_prdata = CSR_DATA_W'(damping_ff);
         CSR_NAT_FREQ:  csr_prdata = CSR_DATA_W'(nat_freq_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Model coefficients, refreshed every cycle from the registers.
   always_comb begin
      w_sq    = SQ_W'(nat_freq_ff) * SQ_W'(nat_freq_ff);
      zw_prod = ZW_W'(damping_ff) * ZW_W'(nat_freq_ff);
      w2_in   = COEF_W'((w_sq + SQ_W'(32'h8000)) >> FRAC_BITS);
      zw2_in  = COEF_W'(((zw_prod << 1) + ZW_W'(12'h800)) >> 12);
      dt_coef = COEF_W'(step_time_ff);
   end

   always_ff @(posedge clock) begin
      w2_ff  <= w2_in;
      zw2_ff <= zw2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_x_ff[k] <= '0;
            hist_y_ff[k] <= '0;
            hist_t_ff[k] <= '0;
         end
      end else if (cmd.load) begin
         hist_x_ff[0] <= req_chan.drive_x;
         hist_y_ff[0] <= req_chan.drive_y;
         hist_t_ff[0] <= req_chan.drive_turn;
      end else if (cmd.shift) begin
         for (int k = 1; k < HISTORY_DEPTH; k++) begin
            hist_x_ff[k] <= hist_x_ff[k-1];
            hist_y_ff[k] <= hist_y_ff[k-1];
            hist_t_ff[k] <= hist_t_ff[k-1];
         end
      end
   end

   dtsp_lane #(.DATA_WIDTH(DW)) u_lane_x (
      .clock(clock), .load(cmd.load), .run(cmd.run), .op(cmd.op),
      .w2(w2_ff), .zw2(zw2_ff), .dt(dt_coef),
      .init_pos(req_chan.pos_x), .init_vel(req_chan.vel_x), .init_acc(req_chan.acc_x),
      .u(hist_x_ff[idx]), .pos(pos[0]), .vel(vel[0]), .acc(acc[0])
   );

   dtsp_lane #(.DATA_WIDTH(DW)) u_lane_y (
      .clock(clock), .load(cmd.load), .run(cmd.run), .op(cmd.op),
      .w2(w2_ff), .zw2(zw2_ff), .dt(dt_coef),
      .init_pos(req_chan.pos_y), .init_vel(req_chan.vel_y), .init_acc(req_chan.acc_y),
      .u(hist_y_ff[idx]), .pos(pos[1]), .vel(vel[1]), .acc(acc[1])
   );

   // Heading starts from zero angular acceleration.
   dtsp_lane #(.DATA_WIDTH(DW)) u_lane_turn (
      .clock(clock), .load(cmd.load), .run(cmd.run), .op(cmd.op),
      .w2(w2_ff), .zw2(zw2_ff), .dt(dt_coef),
      .init_pos(req_chan.heading), .init_vel(req_chan.turn_rate), .init_acc('0),
      .u(hist_t_ff[idx]), .pos(pos[2]), .vel(vel[2]), .acc(acc[2])
   );

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int a = 0; a < 3; a++) begin
            out_ff[a]     <= pos[a];
            out_ff[3 + a] <= vel[a];
            out_ff[6 + a] <= acc[a];
         end
      end
   end

   assign req_chan.ready          = cmd.in_ready;
   assign rsp_chan.valid          = cmd.out_valid;
   assign rsp_chan.pred_pos_x     = out_ff[0];
   assign rsp_chan.pred_pos_y     = out_ff[1];
   assign rsp_chan.pred_heading   = out_ff[2];
   assign rsp_chan.pred_vel_x     = out_ff[3];
   assign rsp_chan.pred_vel_y     = out_ff[4];
   assign rsp_chan.pred_turn_rate = out_ff[5];
   assign rsp_chan.pred_acc_x     = out_ff[6];
   assign rsp_chan.pred_acc_y     = out_ff[7];
   assign rsp_chan.pred_acc_turn  = out_ff[8];

   assign status.in_valid  = req_chan.valid;
   assign status.out_ready = rsp_chan.ready;

endmodule

// ----- design/dtsp_ctrl.sv -----
// Controller: sequences the Euler steps and the result handoff.
module dtsp_ctrl #(
   parameter int HISTORY_DEPTH = 7,
   parameter int IDX_W         = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dtsp_pkg::ctrl_status_type status,
   output dtsp_pkg::ctrl_cmd_type    cmd,
   output logic [IDX_W-1:0]          idx
);
   import dtsp_pkg::*;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = ~rsp_valid_ff | status.out_ready;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            op_in  = OP_W2U;
            idx_in = IDX_W'(HISTORY_DEPTH - 1);
            if (status.in_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            unique case (op_ff)
               OP_W2U: op_in = OP_W2V;
               OP_W2V: op_in = OP_ZA;
               OP_ZA:  op_in = OP_DTV;
               OP_DTV: op_in = OP_DTA;
               OP_DTA: op_in = OP_DTD;
               OP_DTD: op_in = OP_FIN;
               OP_FIN: begin
                  op_in = OP_W2U;
                  // advance to the next newer command, stop after the newest
                  if (idx_ff == '0) state_in = ST_DONE;
                  else idx_in = idx_ff - IDX_W'(1);
               end
               default: op_in = OP_W2U;
            endcase
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.out_valid = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            cmd.load     = status.in_valid;
         end
         ST_RUN:  cmd.run = 1'b1;
         ST_DONE: begin
            cmd.out_load = out_free;
            cmd.shift    = out_free;
         end
         default: ;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~status.out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_W2U;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign idx = idx_ff;

endmodule

// ----- design/dtsp_checker.sv -----
// Port-level checks of the predictor, bound to the top level.
module dtsp_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pos_x
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again right after a transaction");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after a transaction");

   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("block not ready when a new result appears");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
      else $error("stalled result dropped or changed");

endmodule

bind dead_time_state_predictor dtsp_props u_dtsp_props (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_pos_x(32'(rsp_chan.pred_pos_x))
);

// ----- verif/dtsp_checker.sv -----
// Prediction and result checking for the dead-time state predictor.
module dtsp_checker #(
   parameter int HISTORY_DEPTH = 7,
   parameter int DATA_WIDTH    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   dtsp_req_if.sink                        req_mon,
   dtsp_rsp_if.sink                        rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [dtsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dtsp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dtsp_pkg::*;

   typedef logic signed [DATA_WIDTH-1:0] q_type;
   typedef struct packed {
      q_type pos_x, pos_y, heading, vel_x, vel_y, turn_rate, acc_x, acc_y, acc_turn;
   } forecast_type;

   localparam longint QMAX = (64'sd1 <<< (DATA_WIDTH-1)) - 1;
   localparam longint QMIN = -QMAX - 1;

   logic [STEP_W-1:0] step_time;
   logic [DAMP_W-1:0] damping;
   logic [FREQ_W-1:0] nat_freq;
   longint drive_hist [3][HISTORY_DEPTH];
   forecast_type forecast_q[$];

   function automatic longint clamp(longint x);
      if (x > QMAX) return QMAX;
      if (x < QMIN) return QMIN;
      return x;
   endfunction

   // Rounded Q.16 product, halves away from zero, saturated.
   function automatic longint fix_mul(longint coef, longint val);
      logic signed [127:0] prod;
      logic [127:0] mag;
      logic neg;
      prod = 128'(signed'(coef)) * 128'(signed'(val));
      neg = prod < 0;
      mag = neg ? -prod : prod;
      mag = (mag + (128'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
      if (!neg && mag > 128'(QMAX)) mag = 128'(QMAX);
      if (neg && mag > 128'(QMAX) + 1) mag = 128'(QMAX) + 1;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic forecast_type advance_state(q_type f[11]);
      longint pos[3], vel[3], acc[3];
      longint w2, zw2, dt, u, p, v, a, d;
      forecast_type r;
      dt = step_time;
      w2 = (longint'(nat_freq) * nat_freq + 64'h8000) >>> 16;
      zw2 = (2 * longint'(damping) * nat_freq + 64'h800) >>> 12;
      for (int ax = 0; ax < 3; ax++) begin
         pos[ax] = f[ax];
         vel[ax] = f[3+ax];
         acc[ax] = ax < 2 ? longint'(f[6+ax]) : 0;
         drive_hist[ax][0] = f[8+ax];
      end
      for (int i = HISTORY_DEPTH-1; i >= 0; i--)
         for (int ax = 0; ax < 3; ax++) begin
            u = drive_hist[ax][i];
            p = pos[ax]; v = vel[ax]; a = acc[ax];
            d = clamp(fix_mul(w2, u) - fix_mul(w2, v) - fix_mul(zw2, a));
            pos[ax] = clamp(p + fix_mul(dt, v));
            vel[ax] = clamp(v + fix_mul(dt, a));
            acc[ax] = clamp(a + fix_mul(dt, d));
         end
      for (int ax = 0; ax < 3; ax++)
         for (int k = HISTORY_DEPTH-1; k > 0; k--)
            drive_hist[ax][k] = drive_hist[ax][k-1];
      r = '{q_type'(pos[0]), q_type'(pos[1]), q_type'(pos[2]),
            q_type'(vel[0]), q_type'(vel[1]), q_type'(vel[2]),
            q_type'(acc[0]), q_type'(acc[1]), q_type'(acc[2])};
      return r;
   endfunction

   task automatic compare_field(string name, q_type want, q_type got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      forecast_type want;
      q_type f[11];
      if (reset) begin
         step_time <= STEP_TIME_RESET;
         damping <= DAMPING_RESET;
         nat_freq <= NAT_FREQ_RESET;
         for (int ax = 0; ax < 3; ax++)
            for (int k = 0; k < HISTORY_DEPTH; k++) drive_hist[ax][k] = 0;
         forecast_q.delete();
         fail_count <= 0;
         result_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            case (csr_idx_type'(csr_paddr >> 2))
               CSR_STEP_TIME: step_time <= csr_pwdata[STEP_W-1:0];
               CSR_DAMPING:   damping <= csr_pwdata[DAMP_W-1:0];
               CSR_NAT_FREQ:  nat_freq <= csr_pwdata[FREQ_W-1:0];
               default: ;
            endcase
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count <= result_count + 1;
            if (forecast_q.size() == 0) begin
               $error("result transaction with no prediction waiting");
               fail_count++;
            end else begin
               want = forecast_q.pop_front();
               compare_field("pred_pos_x", want.pos_x, rsp_mon.pred_pos_x);
               compare_field("pred_pos_y", want.pos_y, rsp_mon.pred_pos_y);
               compare_field("pred_heading", want.heading, rsp_mon.pred_heading);
               compare_field("pred_vel_x", want.vel_x, rsp_mon.pred_vel_x);
               compare_field("pred_vel_y", want.vel_y, rsp_mon.pred_vel_y);
               compare_field("pred_turn_rate", want.turn_rate, rsp_mon.pred_turn_rate);
               compare_field("pred_acc_x", want.acc_x, rsp_mon.pred_acc_x);
               compare_field("pred_acc_y", want.acc_y, rsp_mon.pred_acc_y);
               compare_field("pred_acc_turn", want.acc_turn, rsp_mon.pred_acc_turn);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            f = '{req_mon.pos_x, req_mon.pos_y, req_mon.heading, req_mon.vel_x,
                  req_mon.vel_y, req_mon.turn_rate, req_mon.acc_x, req_mon.acc_y,
                  req_mon.drive_x, req_mon.drive_y, req_mon.drive_turn};
            forecast_q.push_back(advance_state(f));
         end
         pending_count <= forecast_q.size();
      end
   end
endmodule

// ----- verif/dead_time_state_predictor_tb.sv -----
// Stimulus, register setup and verdict for the dead-time state predictor.
module dead_time_state_predictor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtsp_pkg::*;

   localparam int DW = 32;
   localparam int LATENCY = 60;
   localparam longint CYCLE_LIMIT = 900000;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending_count, result_count;
   longint cycle_count = 0;
   int hold_off_cycles = 0;
   bit calm_rx = 0, calm_tx = 0;
   int sent_count = 0;

   dtsp_req_if #(DW) req_chan();
   dtsp_rsp_if #(DW) rsp_chan();

   dead_time_state_predictor dut (
      .clock, .reset, .req_chan, .rsp_chan,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   dtsp_checker chk (
      .clock, .reset, .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending_count, .result_count
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dead_time_state_predictor regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, plus a counted hold-off on request.
   initial rsp_chan.ready = 0;
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready <= 0;
      end else rsp_chan.ready <= calm_rx || ($urandom_range(99) >= 34);
   end

   initial begin
      req_chan.valid = 0;
      {req_chan.pos_x, req_chan.pos_y, req_chan.heading, req_chan.vel_x, req_chan.vel_y,
       req_chan.turn_rate, req_chan.acc_x, req_chan.acc_y, req_chan.drive_x,
       req_chan.drive_y, req_chan.drive_turn} = '0;
   end

   task automatic csr_write(csr_idx_type idx, logic [CSR_DATA_W-1:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   function automatic logic [DW-1:0] pick_value(int mode);
      case (mode)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 0;
         3: return $urandom;
         default: return DW'($signed($urandom_range(400000)) - 200000);
      endcase
   endfunction

   // Valid stays high between back-to-back transactions; drop it only for a gap.
   task automatic send_item(int mode, bit gaps);
      if (gaps && !calm_tx && $urandom_range(99) < 34) begin
         req_chan.valid <= 0;
         do @(posedge clock); while (!calm_tx && $urandom_range(99) < 34);
      end
      req_chan.valid <= 1;
      req_chan.pos_x <= pick_value(mode);
      req_chan.pos_y <= pick_value(mode);
      req_chan.heading <= pick_value(mode);
      req_chan.vel_x <= pick_value(mode);
      req_chan.vel_y <= pick_value(mode);
      req_chan.turn_rate <= pick_value(mode);
      req_chan.acc_x <= pick_value(mode);
      req_chan.acc_y <= pick_value(mode);
      req_chan.drive_x <= pick_value(mode);
      req_chan.drive_y <= pick_value(mode);
      req_chan.drive_turn <= pick_value(mode);
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) calm_tx = 1;
         if (i == count / 2 + 40) calm_tx = 0;
         send_item($urandom_range(99) < 10 ? $urandom_range(2) : 3 + $urandom_range(1), 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes and random values with reset coefficients
      for (int m = 0; m < 5; m++) send_item(m, 0);
      for (int m = 0; m < 3; m++) send_item(m, 1);
      drain();
      // extreme coefficients
      csr_write(CSR_STEP_TIME, 32'hFFFF);
      csr_write(CSR_DAMPING, 32'hFFFF);
      csr_write(CSR_NAT_FREQ, 32'hFFFF_FFFF);
      for (int m = 0; m < 5; m++) send_item(m, 0);
      drain();
      csr_write(CSR_STEP_TIME, 0);
      csr_write(CSR_DAMPING, 0);
      csr_write(CSR_NAT_FREQ, 0);
      for (int m = 0; m < 5; m++) send_item(m, 0);
      drain();
      // receiver holds off while the sender keeps offering
      csr_write(CSR_STEP_TIME, 32'd1092);
      csr_write(CSR_DAMPING, 32'd4096);
      csr_write(CSR_NAT_FREQ, 32'd655360);
      hold_off_cycles = 600;
      for (int i = 0; i < 6; i++) send_item(3, 0);
      drain();
      calm_rx = 1;
      random_phase(150);
      calm_rx = 0;
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         csr_write(CSR_STEP_TIME, $urandom);
         csr_write(CSR_DAMPING, $urandom);
         csr_write(CSR_NAT_FREQ, $urandom);
         random_phase(300);
      end
      drain();
      $display("Covered %0d items, %0d results, field extremes, zero and maximum",
               sent_count, result_count);
      $display("coefficients, a long output stall and six random coefficient sets.");
      if (fail_count == 0)
         $display("dead_time_state_predictor regression: pass");
      else
         $display("dead_time_state_predictor regression: fail");
      $finish;
   end
endmodule
